// ===== rtl/first_fit_region_allocator_defines.svh =====
// Assertion macros shared by the allocator RTL.
// Define ASSERT_OFF to compile the checks out.
`ifndef FIRST_FIT_REGION_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_REGION_ALLOCATOR_DEFINES_SVH
`ifndef ASSERT_OFF
`define FRA_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("allocator assertion failed");
`define FRA_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("allocator assertion failed");
`else
`define FRA_ASSERT(lbl, clk, rst, prop)
`define FRA_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== rtl/fra_pkg.sv =====
// Types, codes and constants of the first-fit region allocator.
// No dependencies.
`timescale 1ns / 1ps
package fra_pkg;

   localparam int FRAG_COUNT = 64;
   localparam int IDX_W = $clog2(FRAG_COUNT);
   localparam int GRAN_BYTES = 4096;
   localparam logic [31:0] POOL_RESET = 32'd268435456;

   typedef logic [IDX_W-1:0] idx_type;

   typedef enum logic [1:0] {
      KIND_ALLOC = 2'd0,
      KIND_FREE  = 2'd1,
      KIND_INIT  = 2'd2,
      KIND_NOP   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NOSPACE = 2'd1,
      ST_FULL    = 2'd2,
      ST_BADH    = 2'd3
   } status_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_LATCH, OP_INIT, OP_CHK, OP_IDSTEP, OP_SADDR, OP_SPAD, OP_SCMP,
      OP_CARVE1, OP_CARVE2, OP_TAKE, OP_FCHK, OP_FA, OP_FB, OP_FC, OP_FD, OP_FW
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic chk_fail;
      logic id_hit;
      logic id_last;
      logic i_free;
      logic i_last;
      logic fit_gt;
      logic fit_eq;
      logic nid_zero;
      logic h_bad;
   } stat_type;

endpackage

// ===== rtl/fra_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module fra_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/fra_datapath.sv =====
// Fragment table, masks, scan arithmetic and result registers of the allocator.
// Depends on fra_pkg and fra_ram.
`timescale 1ns / 1ps
module fra_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  fra_pkg::cmd_type      cmd,
   output fra_pkg::stat_type     stat,
   input  logic [31:0]           pool_size,
   input  logic [31:0]           req_request_size,
   input  logic [4:0]            req_align_shift,
   input  logic [5:0]            req_free_handle,
   output logic [1:0]            rsp_status,
   output logic [31:0]           rsp_alloc_offset,
   output logic [31:0]           rsp_alloc_size,
   output logic [5:0]            rsp_handle,
   output logic [31:0]           rsp_free_bytes
);
   import fra_pkg::*;

   localparam logic [32:0] GMASK = 33'(GRAN_BYTES - 1);
   localparam idx_type LAST_IDX = IDX_W'(FRAG_COUNT - 1);
   localparam idx_type ONE_IDX = IDX_W'(1);

   logic [FRAG_COUNT-1:0] used_ff, used_in, free_ff, free_in, id_ff, id_in;
   logic [31:0] avail_ff, avail_in;
   logic [31:0] req_ff, req_in;
   logic [4:0]  shift_ff, shift_in;
   idx_type     h_ff, h_in, i_ff, i_in, j_ff, j_in, nid_ff, nid_in;
   idx_type     p_ff, p_in, n_ff, n_in, nn_ff, nn_in;
   logic [32:0] size_ff, size_in;
   logic [31:0] off_ff, off_in, fsz_ff, fsz_in, pad_ff, pad_in;
   logic [32:0] actual_ff, actual_in;
   logic [31:0] hsz_ff, hsz_in, psz_ff, psz_in, nsz_ff, nsz_in, ph_ff, ph_in;
   status_type  res_st_ff, res_st_in;
   logic [31:0] res_off_ff, res_off_in, res_size_ff, res_size_in;
   idx_type     res_h_ff, res_h_in;

   logic        off_we, size_we, prev_we, next_we;
   idx_type     off_wa, size_wa, prev_wa, next_wa, rd_addr;
   logic [31:0] off_wd, size_wd, off_rd, size_rd;
   idx_type     prev_wd, next_wd, prev_rd, next_rd;

   logic [32:0] rnd_size, amask, aligned;
   logic [32:0] actual_c;
   logic        pf, nf;

   fra_ram #(.WIDTH(32), .DEPTH(FRAG_COUNT)) u_off_ram (
      .clock, .wr_en(off_we), .wr_addr(off_wa), .wr_data(off_wd),
      .rd_addr, .rd_data(off_rd));
   fra_ram #(.WIDTH(32), .DEPTH(FRAG_COUNT)) u_size_ram (
      .clock, .wr_en(size_we), .wr_addr(size_wa), .wr_data(size_wd),
      .rd_addr, .rd_data(size_rd));
   fra_ram #(.WIDTH(IDX_W), .DEPTH(FRAG_COUNT)) u_prev_ram (
      .clock, .wr_en(prev_we), .wr_addr(prev_wa), .wr_data(prev_wd),
      .rd_addr, .rd_data(prev_rd));
   fra_ram #(.WIDTH(IDX_W), .DEPTH(FRAG_COUNT)) u_next_ram (
      .clock, .wr_en(next_we), .wr_addr(next_wa), .wr_data(next_wd),
      .rd_addr, .rd_data(next_rd));

   assign rnd_size = ({1'b0, req_ff} + GMASK) & ~GMASK;
   assign amask    = (33'd1 << shift_ff) - 33'd1;
   assign aligned  = ({1'b0, off_rd} + amask) & ~amask;
   assign actual_c = size_ff + {1'b0, pad_ff};
   assign pf       = (p_ff != '0) && free_ff[p_ff];
   assign nf       = (n_ff != '0) && free_ff[n_ff];

   always_comb begin
      stat.chk_fail = rnd_size[32] || (rnd_size[31:0] > avail_ff);
      stat.id_hit   = !id_ff[j_ff];
      stat.id_last  = (j_ff == LAST_IDX);
      stat.i_free   = free_ff[i_ff];
      stat.i_last   = (i_ff == LAST_IDX);
      stat.fit_gt   = {1'b0, fsz_ff} > actual_c;
      stat.fit_eq   = (fsz_ff == size_ff[31:0]) && (pad_ff == '0);
      stat.nid_zero = (nid_ff == '0);
      stat.h_bad    = (h_ff == '0) || !used_ff[h_ff];
   end

   always_comb begin
      case (cmd.op)
         OP_FCHK: rd_addr = h_ff;
         OP_FB:   rd_addr = p_ff;
         OP_FC:   rd_addr = n_ff;
         default: rd_addr = i_ff;
      endcase
   end

   always_comb begin
      used_in = used_ff;    free_in = free_ff;    id_in = id_ff;
      avail_in = avail_ff;  req_in = req_ff;      shift_in = shift_ff;
      h_in = h_ff;  i_in = i_ff;  j_in = j_ff;  nid_in = nid_ff;
      p_in = p_ff;  n_in = n_ff;  nn_in = nn_ff;
      size_in = size_ff;  off_in = off_ff;  fsz_in = fsz_ff;  pad_in = pad_ff;
      actual_in = actual_ff;
      hsz_in = hsz_ff;  psz_in = psz_ff;  nsz_in = nsz_ff;  ph_in = ph_ff;
      res_st_in = res_st_ff;  res_off_in = res_off_ff;
      res_size_in = res_size_ff;  res_h_in = res_h_ff;
      off_we = 1'b0;   off_wa = i_ff;   off_wd = off_ff;
      size_we = 1'b0;  size_wa = i_ff;  size_wd = fsz_ff;
      prev_we = 1'b0;  prev_wa = i_ff;  prev_wd = p_ff;
      next_we = 1'b0;  next_wa = i_ff;  next_wd = n_ff;
      case (cmd.op)
         OP_LATCH: begin
            req_in = req_request_size;
            shift_in = req_align_shift;
            h_in = req_free_handle;
            res_st_in = ST_OK;
            res_off_in = '0;
            res_size_in = '0;
            res_h_in = '0;
         end
         OP_INIT: begin
            used_in = '0;
            free_in = '0;
            id_in = '0;
            free_in[ONE_IDX] = 1'b1;
            id_in[ONE_IDX] = 1'b1;
            avail_in = pool_size;
            off_we = 1'b1;   off_wa = ONE_IDX;   off_wd = '0;
            size_we = 1'b1;  size_wa = ONE_IDX;  size_wd = pool_size;
            prev_we = 1'b1;  prev_wa = ONE_IDX;  prev_wd = '0;
            next_we = 1'b1;  next_wa = ONE_IDX;  next_wd = '0;
         end
         OP_CHK: begin
            size_in = rnd_size;
            j_in = ONE_IDX;
            i_in = ONE_IDX;
            nid_in = '0;
            if (stat.chk_fail) begin
               res_st_in = ST_NOSPACE;
            end
         end
         OP_IDSTEP: begin
            if (stat.id_hit) begin
               nid_in = j_ff;
            end
            j_in = j_ff + ONE_IDX;
         end
         OP_SADDR: begin
            if (!stat.i_free) begin
               i_in = i_ff + ONE_IDX;
               if (stat.i_last) begin
                  res_st_in = ST_NOSPACE;
               end
            end
         end
         OP_SPAD: begin
            off_in = off_rd;
            fsz_in = size_rd;
            p_in = prev_rd;
            pad_in = 32'(aligned - {1'b0, off_rd});
         end
         OP_SCMP: begin
            actual_in = actual_c;
            if (stat.fit_gt) begin
               if (stat.nid_zero) begin
                  res_st_in = ST_FULL;
               end
            end else if (!stat.fit_eq) begin
               if (stat.i_last) begin
                  res_st_in = ST_NOSPACE;
               end else begin
                  i_in = i_ff + ONE_IDX;
               end
            end
         end
         OP_CARVE1: begin
            off_we = 1'b1;   off_wa = nid_ff;   off_wd = off_ff;
            size_we = 1'b1;  size_wa = nid_ff;  size_wd = actual_ff[31:0];
            prev_we = 1'b1;  prev_wa = nid_ff;  prev_wd = p_ff;
            next_we = 1'b1;  next_wa = nid_ff;  next_wd = i_ff;
            used_in[nid_ff] = 1'b1;
            id_in[nid_ff] = 1'b1;
            avail_in = avail_ff - actual_ff[31:0];
            res_off_in = off_ff;
            res_size_in = actual_ff[31:0];
            res_h_in = nid_ff;
         end
         OP_CARVE2: begin
            off_we = 1'b1;   off_wa = i_ff;   off_wd = off_ff + actual_ff[31:0];
            size_we = 1'b1;  size_wa = i_ff;  size_wd = fsz_ff - actual_ff[31:0];
            prev_we = 1'b1;  prev_wa = i_ff;  prev_wd = nid_ff;
            next_we = (p_ff != '0);  next_wa = p_ff;  next_wd = nid_ff;
         end
         OP_TAKE: begin
            avail_in = avail_ff - size_ff[31:0];
            used_in[i_ff] = 1'b1;
            free_in[i_ff] = 1'b0;
            res_off_in = off_ff;
            res_size_in = size_ff[31:0];
            res_h_in = i_ff;
         end
         OP_FCHK: begin
            if (stat.h_bad) begin
               res_st_in = ST_BADH;
            end
         end
         OP_FA: begin
            hsz_in = size_rd;
            p_in = prev_rd;
            n_in = next_rd;
            avail_in = avail_ff + size_rd;
            used_in[h_ff] = 1'b0;
         end
         OP_FB: begin
         end
         OP_FC: begin
            psz_in = size_rd;
         end
         OP_FD: begin
            nsz_in = size_rd;
            nn_in = next_rd;
            ph_in = psz_ff + hsz_ff;
         end
         OP_FW: begin
            if (pf && nf) begin
               size_we = 1'b1;  size_wa = p_ff;  size_wd = ph_ff + nsz_ff;
               next_we = 1'b1;  next_wa = p_ff;  next_wd = nn_ff;
               prev_we = (nn_ff != '0);  prev_wa = nn_ff;  prev_wd = p_ff;
               free_in[n_ff] = 1'b0;
               id_in[n_ff] = 1'b0;
               id_in[h_ff] = 1'b0;
            end else if (pf) begin
               size_we = 1'b1;  size_wa = p_ff;  size_wd = ph_ff;
               next_we = 1'b1;  next_wa = p_ff;  next_wd = n_ff;
               prev_we = (n_ff != '0);  prev_wa = n_ff;  prev_wd = p_ff;
               id_in[h_ff] = 1'b0;
            end else if (nf) begin
               size_we = 1'b1;  size_wa = h_ff;  size_wd = hsz_ff + nsz_ff;
               next_we = 1'b1;  next_wa = h_ff;  next_wd = nn_ff;
               prev_we = (nn_ff != '0);  prev_wa = nn_ff;  prev_wd = h_ff;
               free_in[n_ff] = 1'b0;
               id_in[n_ff] = 1'b0;
               free_in[h_ff] = 1'b1;
            end else begin
               free_in[h_ff] = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff  <= '0;
         free_ff  <= '0;
         id_ff    <= '0;
         avail_ff <= '0;
      end else begin
         used_ff  <= used_in;
         free_ff  <= free_in;
         id_ff    <= id_in;
         avail_ff <= avail_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;      shift_ff <= shift_in;
      h_ff <= h_in;  i_ff <= i_in;  j_ff <= j_in;  nid_ff <= nid_in;
      p_ff <= p_in;  n_ff <= n_in;  nn_ff <= nn_in;
      size_ff <= size_in;  off_ff <= off_in;  fsz_ff <= fsz_in;  pad_ff <= pad_in;
      actual_ff <= actual_in;
      hsz_ff <= hsz_in;  psz_ff <= psz_in;  nsz_ff <= nsz_in;  ph_ff <= ph_in;
      res_st_ff <= res_st_in;  res_off_ff <= res_off_in;
      res_size_ff <= res_size_in;  res_h_ff <= res_h_in;
   end

   assign rsp_status       = res_st_ff;
   assign rsp_alloc_offset = res_off_ff;
   assign rsp_alloc_size   = res_size_ff;
   assign rsp_handle       = 6'(res_h_ff);
   assign rsp_free_bytes   = avail_ff;
endmodule

// ===== rtl/fra_ctrl.sv =====
// Sequencer of the allocator: walks each command through the datapath steps.
// Depends on fra_pkg and first_fit_region_allocator_defines.svh.
`timescale 1ns / 1ps
`include "first_fit_region_allocator_defines.svh"
module fra_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [1:0]        req_kind,
   output logic              busy,
   output logic              rsp_valid,
   output fra_pkg::cmd_type  cmd,
   input  fra_pkg::stat_type stat
);
   import fra_pkg::*;

   typedef enum logic [16:0] {
      S_IDLE   = 17'h00001,
      S_CHK    = 17'h00002,
      S_IDS    = 17'h00004,
      S_SADDR  = 17'h00008,
      S_SPAD   = 17'h00010,
      S_SCMP   = 17'h00020,
      S_CARVE1 = 17'h00040,
      S_CARVE2 = 17'h00080,
      S_TAKE   = 17'h00100,
      S_FCHK   = 17'h00200,
      S_FA     = 17'h00400,
      S_FB     = 17'h00800,
      S_FC     = 17'h01000,
      S_FD     = 17'h02000,
      S_FW     = 17'h04000,
      S_INIT   = 17'h08000,
      S_DONE   = 17'h10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd.op = OP_NONE;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.op = OP_LATCH;
               case (req_kind)
                  KIND_ALLOC: state_in = S_CHK;
                  KIND_FREE:  state_in = S_FCHK;
                  KIND_INIT:  state_in = S_INIT;
                  default:    state_in = S_DONE;
               endcase
            end
         end
         S_CHK: begin
            cmd.op = OP_CHK;
            state_in = stat.chk_fail ? S_DONE : S_IDS;
         end
         S_IDS: begin
            cmd.op = OP_IDSTEP;
            if (stat.id_hit || stat.id_last) begin
               state_in = S_SADDR;
            end
         end
         S_SADDR: begin
            cmd.op = OP_SADDR;
            if (stat.i_free) begin
               state_in = S_SPAD;
            end else if (stat.i_last) begin
               state_in = S_DONE;
            end
         end
         S_SPAD: begin
            cmd.op = OP_SPAD;
            state_in = S_SCMP;
         end
         S_SCMP: begin
            cmd.op = OP_SCMP;
            if (stat.fit_gt) begin
               state_in = stat.nid_zero ? S_DONE : S_CARVE1;
            end else if (stat.fit_eq) begin
               state_in = S_TAKE;
            end else begin
               state_in = stat.i_last ? S_DONE : S_SADDR;
            end
         end
         S_CARVE1: begin
            cmd.op = OP_CARVE1;
            state_in = S_CARVE2;
         end
         S_CARVE2: begin
            cmd.op = OP_CARVE2;
            state_in = S_DONE;
         end
         S_TAKE: begin
            cmd.op = OP_TAKE;
            state_in = S_DONE;
         end
         S_FCHK: begin
            cmd.op = OP_FCHK;
            state_in = stat.h_bad ? S_DONE : S_FA;
         end
         S_FA: begin
            cmd.op = OP_FA;
            state_in = S_FB;
         end
         S_FB: begin
            cmd.op = OP_FB;
            state_in = S_FC;
         end
         S_FC: begin
            cmd.op = OP_FC;
            state_in = S_FD;
         end
         S_FD: begin
            cmd.op = OP_FD;
            state_in = S_FW;
         end
         S_FW: begin
            cmd.op = OP_FW;
            state_in = S_DONE;
         end
         S_INIT: begin
            cmd.op = OP_INIT;
            state_in = S_DONE;
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_DONE);

   `FRA_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> (state_ff == S_IDLE))
   `FRA_ASSERT(a_done_one_cycle, clock, reset, rsp_valid |=> !busy)
   `FRA_ASSERT(a_start_takes, clock, reset, (start && !busy) |=> busy)
   `FRA_ASSERT(a_idle_no_cmd, clock, reset, (!busy && !start) |-> (cmd.op == OP_NONE))
endmodule

// ===== rtl/first_fit_region_allocator.sv =====
// Top level of the first-fit region allocator: register port, sequencer, datapath.
// Depends on fra_pkg, fra_ctrl, fra_datapath and fra_ram.
//
//   channel   handshake                      payload
//   request   start / busy                   req_kind, req_request_size,
//                                            req_align_shift, req_free_handle
//   response  rsp_valid (one-cycle strobe)   rsp_status, rsp_alloc_offset,
//                                            rsp_alloc_size, rsp_handle, rsp_free_bytes
//   register  psel/penable/pwrite, pready=1  paddr, pwdata, prdata (pool_size at 0 to 3)
//
// Init writes the first free fragment; a no-op kind goes straight to the result. Free checks
// the handle, then reads the fragment and its neighbours and writes the merge, ending early on
// a bad handle. Allocate first searches for a free table index, then walks the table in index
// order and tests each free entry for fit. busy stays high from acceptance until the result strobe.
// Reset is synchronous; the pool is empty until an init. Results cannot be stalled.
`timescale 1ns / 1ps
module first_fit_region_allocator (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_kind,
   input  logic [31:0] req_request_size,
   input  logic [4:0]  req_align_shift,
   input  logic [5:0]  req_free_handle,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_alloc_offset,
   output logic [31:0] rsp_alloc_size,
   output logic [5:0]  rsp_handle,
   output logic [31:0] rsp_free_bytes,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import fra_pkg::*;

   logic [31:0] pool_ff, pool_in;
   cmd_type     cmd;
   stat_type    stat;

   always_comb begin
      pool_in = pool_ff;
      if (psel && penable && pwrite && !paddr[2]) begin
         pool_in = pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_ff <= POOL_RESET;
      end else begin
         pool_ff <= pool_in;
      end
   end

   assign pready = 1'b1;
   assign prdata = paddr[2] ? 32'd0 : pool_ff;

   fra_ctrl u_ctrl (
      .clock, .reset, .start, .req_kind, .busy, .rsp_valid, .cmd, .stat);

   fra_datapath u_dp (
      .clock, .reset, .cmd, .stat, .pool_size(pool_ff),
      .req_request_size, .req_align_shift, .req_free_handle,
      .rsp_status, .rsp_alloc_offset, .rsp_alloc_size, .rsp_handle, .rsp_free_bytes);
endmodule
